/* src/prf_pkg.sv */
// Shared types and constants for the pointer ring FIFO.
// Used by prf_ctrl, prf_datapath and pointer_ring_fifo; no dependencies.
package prf_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CAP_W    = IDX_W + 1;
  localparam int HANDLE_W = 32;
  localparam int OP_W     = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ       = 3'd0,
    OP_DEQ       = 3'd1,
    OP_ADV_REAR  = 3'd2,
    OP_ADV_FRONT = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cap_zero;
    logic need_norm;
  } dp_stat_t;

endpackage

/* src/prf_ctrl.sv */
// Controller FSM for the pointer ring FIFO: sequences load, index
// normalization and execute, and owns the result valid. Uses prf_pkg.
module prf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  prf_pkg::dp_stat_t    stat,
  output prf_pkg::ctrl_cmd_t   cmd
);
  import prf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // reduce stale indices one subtraction per cycle
        if (stat.cap_zero || !stat.need_norm) begin
          state_nxt = ST_EXEC;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_EXEC: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* src/prf_datapath.sv */
// Datapath for the pointer ring FIFO: capacity register, indices, full flag,
// slot memory and result registers. Uses prf_pkg; driven by prf_ctrl.
module prf_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  prf_pkg::ctrl_cmd_t               cmd,
  output prf_pkg::dp_stat_t                stat,
  input  logic                             cfg_valid,
  input  logic [prf_pkg::CAP_W-1:0]        cfg_capacity,
  input  logic [prf_pkg::OP_W-1:0]         in_op,
  input  logic [prf_pkg::HANDLE_W-1:0]     in_entry_in,
  input  logic [prf_pkg::CAP_W-1:0]        in_count,
  output logic                             out_ok,
  output logic [prf_pkg::HANDLE_W-1:0]     out_entry_out,
  output logic [prf_pkg::CAP_W-1:0]        out_moved,
  output logic [prf_pkg::CAP_W-1:0]        out_used_slots,
  output logic [prf_pkg::CAP_W-1:0]        out_free_slots,
  output logic [prf_pkg::IDX_W-1:0]        out_head_index,
  output logic [prf_pkg::IDX_W-1:0]        out_tail_index
);
  import prf_pkg::*;

  function automatic logic [CAP_W-1:0] used_of(input logic [CAP_W-1:0] cap,
                                               input logic             full,
                                               input logic [IDX_W-1:0] h,
                                               input logic [IDX_W-1:0] t);
    logic [CAP_W-1:0] res;
    if (cap == '0) begin
      res = '0;
    end else if (full) begin
      res = cap;
    end else if (t >= h) begin
      res = {1'b0, t} - {1'b0, h};
    end else begin
      res = cap - ({1'b0, h} - {1'b0, t});
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [CAP_W-1:0] n,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] s;
    logic [CAP_W:0] r;
    s = {2'b00, idx} + {1'b0, n};
    r = (s >= {1'b0, cap}) ? s - {1'b0, cap} : s;
    return r[IDX_W-1:0];
  endfunction

  logic [CAP_W-1:0]    cap_r;
  logic [IDX_W-1:0]    head_r, tail_r;
  logic                full_r;
  logic [OP_W-1:0]     op_r;
  logic [HANDLE_W-1:0] entry_r;
  logic [CAP_W-1:0]    cnt_r;
  logic [HANDLE_W-1:0] rd_data_r;
  logic [HANDLE_W-1:0] mem [DEPTH];

  logic                ok_r;
  logic [HANDLE_W-1:0] taken_r;
  logic [CAP_W-1:0]    moved_r, used_r, free_r;
  logic [IDX_W-1:0]    head_out_r, tail_out_r;

  logic [CAP_W-1:0]    eff_cap;
  logic                head_ge, tail_ge;
  logic [IDX_W-1:0]    head_nxt, tail_nxt;
  logic                full_nxt, ok_nxt, wr_en;
  logic [HANDLE_W-1:0] taken_nxt;
  logic [CAP_W-1:0]    moved_nxt, used0, free0, used1, free1;

  assign eff_cap = (cap_r > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_r;
  assign head_ge = ({1'b0, head_r} >= eff_cap);
  assign tail_ge = ({1'b0, tail_r} >= eff_cap);

  assign stat = '{cap_zero: (eff_cap == '0), need_norm: (head_ge || tail_ge)};

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    full_nxt  = full_r;
    ok_nxt    = 1'b0;
    taken_nxt = '0;
    moved_nxt = '0;
    wr_en     = 1'b0;
    used0     = used_of(eff_cap, full_r, head_r, tail_r);
    free0     = eff_cap - used0;
    if (eff_cap == '0) begin
      // disabled queue: clear still resets the indices but reports failure
      if (op_r == OP_CLEAR) begin
        head_nxt = '0;
        tail_nxt = '0;
        full_nxt = 1'b0;
      end
    end else begin
      case (op_t'(op_r))
        OP_ENQ: begin
          if (entry_r != '0 && !full_r) begin
            wr_en    = 1'b1;
            tail_nxt = wrap_add(tail_r, CAP_W'(1), eff_cap);
            full_nxt = (tail_nxt == head_r);
            ok_nxt   = 1'b1;
          end
        end
        OP_DEQ: begin
          if (used0 != '0) begin
            taken_nxt = rd_data_r;
            head_nxt  = wrap_add(head_r, CAP_W'(1), eff_cap);
            full_nxt  = 1'b0;
            ok_nxt    = 1'b1;
          end
        end
        OP_ADV_REAR: begin
          if (cnt_r <= free0) begin
            // a zero move leaves the full flag alone
            if (cnt_r != '0) begin
              tail_nxt = wrap_add(tail_r, cnt_r, eff_cap);
              full_nxt = (tail_nxt == head_r);
            end
            moved_nxt = cnt_r;
            ok_nxt    = 1'b1;
          end
        end
        OP_ADV_FRONT: begin
          if (cnt_r <= used0) begin
            if (cnt_r != '0) begin
              head_nxt = wrap_add(head_r, cnt_r, eff_cap);
              full_nxt = 1'b0;
            end
            moved_nxt = cnt_r;
            ok_nxt    = 1'b1;
          end
        end
        OP_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          full_nxt = 1'b0;
          ok_nxt   = 1'b1;
        end
        default: begin
        end
      endcase
    end
    used1 = used_of(eff_cap, full_nxt, head_nxt, tail_nxt);
    free1 = eff_cap - used1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      head_r <= '0;
      tail_r <= '0;
      full_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_capacity;
      end
      if (cmd.norm_step) begin
        if (head_ge) begin
          head_r <= IDX_W'({1'b0, head_r} - eff_cap);
        end
        if (tail_ge) begin
          tail_r <= IDX_W'({1'b0, tail_r} - eff_cap);
        end
      end else if (cmd.exec) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        full_r <= full_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      entry_r <= in_entry_in;
      cnt_r   <= in_count;
    end
    if (cmd.exec) begin
      ok_r       <= ok_nxt;
      taken_r    <= taken_nxt;
      moved_r    <= moved_nxt;
      used_r     <= used1;
      free_r     <= free1;
      head_out_r <= head_nxt;
      tail_out_r <= tail_nxt;
    end
  end

  // slot memory: one write port at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[tail_r] <= entry_r;
    end
    rd_data_r <= mem[head_r];
  end

  assign out_ok         = ok_r;
  assign out_entry_out  = taken_r;
  assign out_moved      = moved_r;
  assign out_used_slots = used_r;
  assign out_free_slots = free_r;
  assign out_head_index = head_out_r;
  assign out_tail_index = tail_out_r;

endmodule

/* src/pointer_ring_fifo.sv */
// Pointer ring FIFO top level: prf_ctrl and prf_datapath, uses prf_pkg.
// Each input beat is loaded, its stale head and tail indices are reduced
// by the capacity one subtraction at a time (stale only after a capacity
// change without a clear), then it is executed into the result registers
// once the output is free. No new beat is taken until it has been executed.
// Reset: synchronous, active low; head, tail and full clear, capacity 16.
module pointer_ring_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [prf_pkg::OP_W-1:0]         in_op,
  input  logic [prf_pkg::HANDLE_W-1:0]     in_entry_in,
  input  logic [prf_pkg::CAP_W-1:0]        in_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_ok,
  output logic [prf_pkg::HANDLE_W-1:0]     out_entry_out,
  output logic [prf_pkg::CAP_W-1:0]        out_moved,
  output logic [prf_pkg::CAP_W-1:0]        out_used_slots,
  output logic [prf_pkg::CAP_W-1:0]        out_free_slots,
  output logic [prf_pkg::IDX_W-1:0]        out_head_index,
  output logic [prf_pkg::IDX_W-1:0]        out_tail_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prf_pkg::CAP_W-1:0]        cfg_capacity
);
  import prf_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  prf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  prf_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .in_op          (in_op),
    .in_entry_in    (in_entry_in),
    .in_count       (in_count),
    .out_ok         (out_ok),
    .out_entry_out  (out_entry_out),
    .out_moved      (out_moved),
    .out_used_slots (out_used_slots),
    .out_free_slots (out_free_slots),
    .out_head_index (out_head_index),
    .out_tail_index (out_tail_index)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.norm_step, cmd.exec}))
    else $error("controller issued more than one command");

  a_exec_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (stat.cap_zero || !stat.need_norm))
    else $error("execute with stale indices");

  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed beat did not reach the output");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while one is in work");

endmodule
